### hw/rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared constants and types for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // Number of storage cells in the chain
  localparam int DEPTH = 16;
  // Width of the occupancy counter, wide enough to hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_W  = 40;
  localparam int OUT_W = 48;

  typedef logic signed [31:0] value_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;  // insert new value, already gated against full
    logic pop;   // remove front, already gated against empty
  } cell_ctl_t;

endpackage

### hw/rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One entry of the sorted chain: compares the incoming value against its own
// entry and either keeps, loads, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module smpq_cell
  import smpq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  value_t    new_val,
  input  logic      used,      // this cell holds a stored value
  input  value_t    left_val,
  input  logic      left_gt,   // left neighbor makes room for the new value
  input  value_t    right_val,
  output value_t    val,
  output value_t    val_next,
  output logic      gt         // this cell moves right on a push
);

  // An empty cell or a strictly larger entry yields to the new value, so
  // equal values keep arrival order
  assign gt = !used || (val > new_val);

  // Select the next entry
  always_comb begin
    val_next = val;
    if (ctl.push) begin
      if (left_gt) begin
        val_next = left_val;
      end else if (gt) begin
        val_next = new_val;
      end
    end else if (ctl.pop) begin
      val_next = right_val;
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

### hw/rtl/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded ascending queue of signed 32-bit values kept sorted in a chain of
// cells; every command returns the front value, flags, count and status.
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, lowest bit first)
//  s_*     | in  | command[1:0], value[33:2], zero pad to 40 bits
//  m_*     | out | front_value[31:0], is_empty[32], is_full[33],
//          |     | count[38:34], status[40:39], zero pad to 48 bits
//
// One command per cycle while the result is taken: every cell compares and
// shifts in the same cycle, and the result is registered for the next edge.
// The result register frees the input side as soon as the result is taken
// or in the same cycle it is taken.
// Reset empties the queue and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue
  import smpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command[1:0], value[33:2]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // front_value, is_empty, is_full, count, status
);

  logic [1:0]       command;
  value_t           value;
  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             empty;
  logic [1:0]       status;
  cell_ctl_t        ctl;
  value_t           vals      [DEPTH];
  value_t           vals_next [DEPTH];
  logic             gts       [DEPTH];
  logic             empty_next;
  logic             full_next;
  value_t           front_next;

  assign command = s_tdata[1:0];
  assign value   = s_tdata[33:2];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // Decode the command into cell control and status
  always_comb begin
    ctl        = '0;
    status     = ST_OK;
    count_next = count;
    if (accept) begin
      case (command)
        CMD_PUSH: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctl.push   = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_POP: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctl.pop    = 1'b1;
            count_next = count - CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    smpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_val   (value),
      .used      (CNT_W'(i) < count),
      .left_val  ((i == 0) ? value_t'(0) : vals[(i == 0) ? 0 : i - 1]),
      .left_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
      .right_val (vals[(i == DEPTH - 1) ? i : i + 1]),
      .val       (vals[i]),
      .val_next  (vals_next[i]),
      .gt        (gts[i])
    );
  end

  assign empty_next = (count_next == '0);
  assign full_next  = (count_next == CNT_W'(DEPTH));
  assign front_next = empty_next ? value_t'(0) : vals_next[0];

  // Advance the occupancy counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0, status, 5'(count_next), full_next, empty_next, front_next};
    end
  end

endmodule

### hw/rtl/smpq_check.sv
// ----------------------------------------------------------------------------
// smpq_check
// Port-level checks for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
module smpq_check
  import smpq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // Stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A clear yields an empty queue with status ok on the next result
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[1:0] == CMD_CLEAR |=>
      m_tvalid && m_tdata[32] && m_tdata[38:34] == 5'd0 && m_tdata[40:39] == ST_OK)
    else $error("clear did not empty the queue");

  // Empty queue shows a zero front value
  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0 && !m_tdata[33])
    else $error("empty result with nonzero front or full flag");

  // Every accepted item produces a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no result");

endmodule

bind sorted_min_priority_queue smpq_check u_smpq_check (.*);
